// File: sv/hash_table_linear_probe_macros.svh
// Assertion macros for the hash table checker.
`ifndef HASH_TABLE_LINEAR_PROBE_MACROS_SVH
`define HASH_TABLE_LINEAR_PROBE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HTLP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define HTLP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/htlp_pkg.sv
// Types and constants shared by the hash table modules.
`default_nettype none
package htlp_pkg;

   localparam int unsigned KEY_W   = 32;
   localparam int unsigned HASH_W  = 32;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned LIMIT_W = 7;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd48;

   localparam logic [1:0] ACTION_GET = 2'd0;
   localparam logic [1:0] ACTION_SET = 2'd1;
   localparam logic [1:0] ACTION_DEL = 2'd2;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [KEY_W-1:0]   key_id;
      logic [HASH_W-1:0]  key_hash;
      logic [VALUE_W-1:0] new_value;
   } req_type;

   typedef struct packed {
      logic               success;
      logic               table_full;
      logic [VALUE_W-1:0] read_value;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         state;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } slot_row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE
   } fsm_type;

endpackage
`default_nettype wire

// File: sv/hash_table_linear_probe.sv
// Top level of the linear-probing key/value table with tombstones.
`default_nettype none
// A request is taken when start is high and busy is low; busy then stays high while the
// table is probed one slot per cycle from the home slot (the low IDX_W bits of
// key_hash), from 1 up to CAPACITY slots per request, a rate bounded by the single
// read port of the slot memory. The result appears on rsp_payload with rsp_strobe
// high for exactly one cycle, the same cycle in which busy drops; the receiver cannot
// stall it, so it must take it then. After reset the block runs a clearing pass over
// all CAPACITY slots with busy high. csr_ready is always high; write max_entries only
// while the block is idle.
module hash_table_linear_probe #(
   parameter int unsigned CAPACITY = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire htlp_pkg::req_type             req_payload,
   output logic                               rsp_strobe,
   output htlp_pkg::rsp_type                  rsp_payload,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [htlp_pkg::LIMIT_W-1:0]  csr_data
);
   import htlp_pkg::*;

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   fsm_type             fsm_ff, fsm_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   rsp_type             rsp_ff, rsp_in;
   logic [LIMIT_W-1:0]  used_ff, used_in;
   logic [LIMIT_W-1:0]  max_ff, max_in;
   logic [IDX_W-1:0]    clr_ff, clr_in;
   req_type             req_ff, req_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    count_ff, count_in;
   logic                have_tomb_ff, have_tomb_in;
   logic [IDX_W-1:0]    tomb_idx_ff, tomb_idx_in;

   logic                accept;
   logic                finish;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   slot_row_type        wr_row;
   logic [IDX_W-1:0]    rd_addr;
   slot_row_type        rd_row;

   logic                slot_empty;
   logic                slot_tomb;
   logic                slot_match;
   logic                tomb_now;
   logic [IDX_W-1:0]    tomb_idx_now;
   logic                have_spot;
   logic                spot_is_empty;
   logic [IDX_W-1:0]    spot_idx;

   htlp_table #(
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_row  (wr_row),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   assign busy        = (fsm_ff != ST_IDLE);
   assign accept      = start && !busy;
   assign csr_ready   = 1'b1;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      slot_empty    = (rd_row.state == SLOT_EMPTY);
      slot_tomb     = (rd_row.state == SLOT_TOMB);
      slot_match    = (rd_row.state == SLOT_USED) && (rd_row.key == req_ff.key_id);
      tomb_now      = have_tomb_ff || slot_tomb;
      tomb_idx_now  = have_tomb_ff ? tomb_idx_ff : idx_ff;
      have_spot     = slot_empty || tomb_now;
      spot_is_empty = slot_empty && !have_tomb_ff;
      spot_idx      = spot_is_empty ? idx_ff : tomb_idx_now;
   end

   // next state
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_IDX) begin
               fsm_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               fsm_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (finish) begin
               fsm_in = ST_IDLE;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // datapath and memory control
   always_comb begin
      finish        = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_row.state  = SLOT_USED;
      wr_row.key    = req_ff.key_id;
      wr_row.value  = req_ff.new_value;
      rd_addr       = idx_ff + IDX_W'(1);
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      used_in       = used_ff;
      max_in        = (csr_valid && csr_ready) ? csr_data : max_ff;
      clr_in        = clr_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      have_tomb_in  = have_tomb_ff;
      tomb_idx_in   = tomb_idx_ff;
      case (fsm_ff)
         ST_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            wr_row.state = SLOT_EMPTY;
            clr_in       = clr_ff + IDX_W'(1);
         end
         ST_IDLE: begin
            rd_addr = req_payload.key_hash[IDX_W-1:0];
            if (accept) begin
               req_in       = req_payload;
               idx_in       = req_payload.key_hash[IDX_W-1:0];
               count_in     = '0;
               have_tomb_in = 1'b0;
            end
         end
         ST_PROBE: begin
            finish = slot_empty || slot_match || (count_ff == LAST_IDX);
            if (!finish) begin
               idx_in       = idx_ff + IDX_W'(1);
               count_in     = count_ff + IDX_W'(1);
               have_tomb_in = tomb_now;
               tomb_idx_in  = tomb_idx_now;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '0;
               case (req_ff.action)
                  ACTION_GET: begin
                     if (slot_match) begin
                        rsp_in.success    = 1'b1;
                        rsp_in.read_value = rd_row.value;
                     end
                  end
                  ACTION_SET: begin
                     if (slot_match) begin
                        wr_en = 1'b1;
                     end else if (!have_spot) begin
                        rsp_in.table_full = 1'b1;
                     end else if (spot_is_empty && (used_ff >= max_ff)) begin
                        rsp_in.table_full = 1'b1;
                     end else begin
                        wr_en          = 1'b1;
                        wr_addr        = spot_idx;
                        rsp_in.success = 1'b1;
                        if (spot_is_empty) begin
                           used_in = used_ff + LIMIT_W'(1);
                        end
                     end
                  end
                  ACTION_DEL: begin
                     if (slot_match) begin
                        wr_en          = 1'b1;
                        wr_row.state   = SLOT_TOMB;
                        wr_row.key     = rd_row.key;
                        wr_row.value   = rd_row.value;
                        rsp_in.success = 1'b1;
                     end
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff        <= ST_CLEAR;
         rsp_strobe_ff <= 1'b0;
         used_ff       <= '0;
         max_ff        <= LIMIT_RESET;
         clr_ff        <= '0;
      end else begin
         fsm_ff        <= fsm_in;
         rsp_strobe_ff <= rsp_strobe_in;
         used_ff       <= used_in;
         max_ff        <= max_in;
         clr_ff        <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      req_ff       <= req_in;
      idx_ff       <= idx_in;
      count_ff     <= count_in;
      have_tomb_ff <= have_tomb_in;
      tomb_idx_ff  <= tomb_idx_in;
   end

endmodule
`default_nettype wire

// File: sv/htlp_table.sv
// Slot memory: one write port, one read port with registered read data.
`default_nettype none
module htlp_table #(
   parameter int unsigned DEPTH = 64,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire htlp_pkg::slot_row_type wr_row,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output htlp_pkg::slot_row_type     rd_row
);
   import htlp_pkg::*;

   slot_row_type mem [DEPTH];
   slot_row_type rd_row_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
   end

   always_ff @(posedge clock) begin
      rd_row_ff <= mem[rd_addr];
   end

   assign rd_row = rd_row_ff;

endmodule
`default_nettype wire

// File: sv/htlp_checker.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none
`include "hash_table_linear_probe_macros.svh"
module htlp_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  rsp_strobe,
   input wire htlp_pkg::rsp_type     rsp_payload
);
   import htlp_pkg::*;

   logic accept;
   logic both_flags;
   logic value_seen;
   logic hit;

   assign accept     = start && !busy;
   assign both_flags = rsp_payload.success && rsp_payload.table_full;
   assign value_seen = rsp_strobe && (rsp_payload.read_value != '0);
   assign hit        = rsp_payload.success;

   `HTLP_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, busy, "busy low after request")
   `HTLP_ASSERT_NEXT(a_quiet_after_accept, clock, reset, accept, !rsp_strobe, "strobe too early")
   `HTLP_ASSERT_NOW(a_strobe_idle, clock, reset, rsp_strobe, !busy, "strobe while busy")
   `HTLP_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_strobe, !both_flags, "both flags set")
   `HTLP_ASSERT_NOW(a_value_needs_hit, clock, reset, value_seen, hit, "value without hit")

endmodule

bind hash_table_linear_probe htlp_checker u_htlp_checker (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_payload (rsp_payload)
);
`default_nettype wire
